// ----- hw/rtl/bflc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the byte FIFO with line count.
package bflc_pkg;

   localparam int SIZE_W  = 7;
   localparam int LINES_W = 6;
   localparam logic [7:0] NL_BYTE = 8'h0A;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_LINE  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef struct packed {
      req_code_type req_type;
      logic [7:0]   data_in;
   } req_pkt_type;

   typedef struct packed {
      logic [7:0]         data_out;
      logic               ok;
      logic               last;
      logic               is_empty;
      logic               is_full;
      logic [LINES_W-1:0] lines_held;
   } rsp_pkt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_LINE
   } ctrl_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic push;
      logic clear;
      logic pop;
      logic line;
      logic pop_done;
      logic line_byte;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic ring_empty;
      logic no_line;
      logic data_nl;
   } stat_type;

endpackage

// ----- hw/rtl/bflc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bflc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bflc_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer and response valid control of the byte FIFO.
module bflc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bflc_pkg::req_code_type req_code,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bflc_pkg::stat_type    stat,
   output bflc_pkg::cmd_type     cmd
);
   import bflc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           accept;
   logic           rsp_load;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code)
                  REQ_PUSH:  cmd.push = 1'b1;
                  REQ_POP: begin
                     cmd.pop = 1'b1;
                     if (!stat.ring_empty) state_in = ST_POP_WAIT;
                  end
                  REQ_LINE: begin
                     cmd.line = 1'b1;
                     if (!stat.no_line) state_in = ST_LINE;
                  end
                  REQ_CLEAR: cmd.clear = 1'b1;
                  default:   cmd.clear = 1'b1;
               endcase
            end
         end
         ST_POP_WAIT: begin
            if (slot_free) begin
               cmd.pop_done = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LINE: begin
            if (slot_free) begin
               cmd.line_byte = 1'b1;
               if (stat.data_nl) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_load = cmd.push || cmd.clear || (cmd.pop && stat.ring_empty) ||
                     (cmd.line && stat.no_line) || cmd.pop_done || cmd.line_byte;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.clear, cmd.pop, cmd.line, cmd.pop_done, cmd.line_byte}))
      else $error("more than one datapath command in a cycle");

   a_pop_wait: assert property (@(posedge clock) disable iff (reset)
      accept && req_code == REQ_POP && !stat.ring_empty |=> state_ff == ST_POP_WAIT)
      else $error("pop of a held byte did not wait for read data");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("response loaded over an untaken response");

endmodule

// ----- hw/rtl/bflc_dpath.sv -----
`timescale 1ns / 1ps
// Ring indices, newline count, flags, ring memory and response register.
module bflc_dpath #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bflc_pkg::cmd_type             cmd,
   input  logic [7:0]                    data_in,
   input  logic                          csr_wr_en,
   input  logic [bflc_pkg::SIZE_W-1:0]   csr_wr_data,
   output bflc_pkg::stat_type            stat,
   output bflc_pkg::rsp_pkt_type         rsp_payload
);
   import bflc_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [SIZE_W-1:0] MAX_SLOTS = SIZE_W'(DEPTH);
   localparam logic [SIZE_W-1:0] MIN_SLOTS = SIZE_W'(2);

   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [LINES_W-1:0] nl_cnt_ff, nl_cnt_in;
   logic               full_ff, full_in;
   logic               tail_nl_ff, tail_nl_in;
   logic [SIZE_W-1:0]  slots_ff, slots_in;
   logic               ln_empty_ff, ln_empty_in;
   logic [LINES_W-1:0] ln_cnt_ff, ln_cnt_in;
   rsp_pkt_type        rsp_ff, rsp_in;

   logic [SIZE_W-1:0]  rd_sum, wr_sum;
   logic [IDX_W-1:0]   rd_nxt, wr_nxt;
   logic               ring_full, ring_empty, no_line, din_nl, data_nl;
   logic               ram_wr_en, ram_rd_en;
   logic [7:0]         ram_rd_data;

   // Advance with wrap at the configured slot count.
   assign rd_sum = SIZE_W'(rd_idx_ff) + SIZE_W'(1);
   assign wr_sum = SIZE_W'(wr_idx_ff) + SIZE_W'(1);
   assign rd_nxt = (rd_sum >= slots_ff) ? '0 : rd_sum[IDX_W-1:0];
   assign wr_nxt = (wr_sum >= slots_ff) ? '0 : wr_sum[IDX_W-1:0];

   assign ring_empty = (rd_idx_ff == wr_idx_ff);
   assign ring_full  = (wr_nxt == rd_idx_ff);
   assign no_line    = (nl_cnt_ff == '0);
   assign din_nl     = (data_in == NL_BYTE);
   assign data_nl    = (ram_rd_data == NL_BYTE);

   assign ram_wr_en = cmd.push && !ring_full;
   assign ram_rd_en = (cmd.pop && !ring_empty) || (cmd.line && !no_line) ||
                      (cmd.line_byte && !data_nl);

   bflc_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      nl_cnt_in   = nl_cnt_ff;
      full_in     = full_ff;
      tail_nl_in  = tail_nl_ff;
      slots_in    = slots_ff;
      ln_empty_in = ln_empty_ff;
      ln_cnt_in   = ln_cnt_ff;
      rsp_in      = rsp_ff;

      if (ram_rd_en) begin
         rd_idx_in = rd_nxt;
      end

      if (csr_wr_en) begin
         if (csr_wr_data < MIN_SLOTS) begin
            slots_in = MIN_SLOTS;
         end else if (csr_wr_data > MAX_SLOTS) begin
            slots_in = MAX_SLOTS;
         end else begin
            slots_in = csr_wr_data;
         end
         rd_idx_in  = '0;
         wr_idx_in  = '0;
         nl_cnt_in  = '0;
         full_in    = 1'b0;
         tail_nl_in = 1'b0;
      end

      if (cmd.push) begin
         rsp_in.data_out = '0;
         rsp_in.last     = 1'b1;
         if (ring_full) begin
            full_in             = 1'b1;
            rsp_in.ok           = 1'b0;
            rsp_in.is_empty     = ring_empty;
            rsp_in.is_full      = 1'b1;
            rsp_in.lines_held   = nl_cnt_ff;
         end else begin
            wr_idx_in           = wr_nxt;
            nl_cnt_in           = nl_cnt_ff + LINES_W'(din_nl);
            tail_nl_in          = din_nl;
            rsp_in.ok           = 1'b1;
            rsp_in.is_empty     = 1'b0;
            rsp_in.is_full      = full_ff;
            rsp_in.lines_held   = nl_cnt_ff + LINES_W'(din_nl);
         end
      end

      if (cmd.clear) begin
         rd_idx_in  = '0;
         wr_idx_in  = '0;
         nl_cnt_in  = '0;
         full_in    = 1'b0;
         tail_nl_in = 1'b0;
         rsp_in     = '{data_out: '0, ok: 1'b1, last: 1'b1, is_empty: 1'b1,
                        is_full: 1'b0, lines_held: '0};
      end

      if (cmd.pop) begin
         if (ring_empty) begin
            rsp_in = '{data_out: '0, ok: 1'b0, last: 1'b1, is_empty: 1'b1,
                       is_full: full_ff, lines_held: nl_cnt_ff};
         end else begin
            full_in = 1'b0;
         end
      end

      if (cmd.line) begin
         if (no_line) begin
            rsp_in = '{data_out: '0, ok: 1'b0, last: 1'b1, is_empty: ring_empty,
                       is_full: full_ff, lines_held: nl_cnt_ff};
         end else begin
            // Final status of the whole line read, shown on every byte.
            full_in     = 1'b0;
            ln_empty_in = (nl_cnt_ff == LINES_W'(1)) && tail_nl_ff;
            ln_cnt_in   = nl_cnt_ff - LINES_W'(1);
         end
      end

      if (cmd.pop_done) begin
         nl_cnt_in = nl_cnt_ff - LINES_W'(data_nl);
         rsp_in    = '{data_out: ram_rd_data, ok: 1'b1, last: 1'b1,
                       is_empty: ring_empty, is_full: 1'b0,
                       lines_held: nl_cnt_ff - LINES_W'(data_nl)};
      end

      if (cmd.line_byte) begin
         nl_cnt_in = nl_cnt_ff - LINES_W'(data_nl);
         rsp_in    = '{data_out: ram_rd_data, ok: 1'b1, last: data_nl,
                       is_empty: ln_empty_ff, is_full: 1'b0, lines_held: ln_cnt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         nl_cnt_ff  <= '0;
         full_ff    <= 1'b0;
         tail_nl_ff <= 1'b0;
         slots_ff   <= MAX_SLOTS;
      end else begin
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         nl_cnt_ff  <= nl_cnt_in;
         full_ff    <= full_in;
         tail_nl_ff <= tail_nl_in;
         slots_ff   <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      ln_empty_ff <= ln_empty_in;
      ln_cnt_ff   <= ln_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign stat.ring_empty = ring_empty;
   assign stat.no_line    = no_line;
   assign stat.data_nl    = data_nl;
   assign rsp_payload     = rsp_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(rd_idx_ff) < slots_ff && SIZE_W'(wr_idx_ff) < slots_ff)
      else $error("ring index beyond configured slot count");

   a_slots_range: assert property (@(posedge clock) disable iff (reset)
      slots_ff >= MIN_SLOTS && slots_ff <= MAX_SLOTS)
      else $error("slot count outside the built depth");

   a_line_held: assert property (@(posedge clock) disable iff (reset)
      cmd.line_byte |-> nl_cnt_ff != '0)
      else $error("line byte streamed with no newline held");

endmodule

// ----- hw/rtl/byte_fifo_with_line_count_core.sv -----
`timescale 1ns / 1ps
// Top level of the circular byte FIFO with a count of held newline bytes.
//
// A ring of csr_wr_data slots (clamped to 2..DEPTH, DEPTH after reset) in a
// DEPTH-deep RAM, one slot always kept empty, so it holds at most size minus
// one bytes. Each request yields one response, except a line read that finds
// a newline held: it streams the bytes up to and including the first newline,
// one response per byte, with last set on the newline. Every response of a
// request carries the empty flag, sticky full flag and newline count as they
// stand once the whole request is done. Push, clear and a pop on an empty
// ring load their response when accepted; a pop that finds a byte waits in
// ST_POP_WAIT for the registered read port of the ring RAM. A line read with
// no newline held is answered the same way; one that finds a newline enters
// ST_LINE and streams its bytes while rsp_ready stays high, the RAM read of
// the next byte overlapping the delivery of this one.
// A new request is taken once the previous one has put out its last response
// and the response register is free or being emptied. Writing the size
// register empties the ring; write it only while no request is in flight.
// No clearing pass runs after reset: the indices and count start at zero.
module byte_fifo_with_line_count_core #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bflc_pkg::req_pkt_type       req_payload,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bflc_pkg::rsp_pkt_type       rsp_payload,
   // size register
   input  logic                        csr_wr_en,
   input  logic [bflc_pkg::SIZE_W-1:0] csr_wr_data
);
   import bflc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Controller: accept requests, sequence pops and line reads, and hold
   // the response valid until the far side takes it.
   bflc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_code  (req_payload.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: ring RAM, indices, newline count, flags, response register.
   bflc_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_in     (req_payload.data_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   // A held response must not change until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // No new request while a response is waiting and not being taken.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken with response register blocked");

   // A line read in progress keeps the request side closed.
   a_line_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> !req_ready)
      else $error("request taken in the middle of a line read");

endmodule
